/* sv/dpbrt_pkg.sv */
// dpbrt_pkg: shared widths, state encoding and run transaction types for the
// demand page bitmap run tracker; no dependencies
`default_nettype none

package dpbrt_pkg;

  localparam int unsigned PAGE_W  = 16;  // page number field
  localparam int unsigned COUNT_W = 8;   // page count field
  localparam int unsigned PNUM_W  = 17;  // page number past the range top

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV1,
    ST_DIV2,
    ST_RD,
    ST_LOAD,
    ST_SCAN,
    ST_WB,
    ST_DIS,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [PAGE_W-1:0]  first_page;
    logic [COUNT_W-1:0] pages;
  } run_t;

  typedef struct packed {
    logic close;  // a run is complete
    logic flush;  // item done, release the held run as last
    run_t run;
  } emit_req_t;

endpackage

`default_nettype wire

/* sv/dpbrt_if.sv */
// dpbrt_req_if / dpbrt_run_if: valid/ready channels for range requests and
// released runs; depends on dpbrt_pkg
`default_nettype none

interface dpbrt_req_if;
  import dpbrt_pkg::*;

  logic               valid;
  logic               ready;
  logic               func;
  logic [PAGE_W-1:0]  first_page;
  logic [COUNT_W-1:0] page_count;

  modport source (output valid, output func, output first_page, output page_count,
                  input ready);
  modport sink   (input valid, input func, input first_page, input page_count,
                  output ready);
endinterface

interface dpbrt_run_if;
  import dpbrt_pkg::*;

  logic               valid;
  logic               ready;
  logic [PAGE_W-1:0]  run_first_page;
  logic [COUNT_W-1:0] run_pages;
  logic               last;

  modport source (output valid, output run_first_page, output run_pages, output last,
                  input ready);
  modport sink   (input valid, input run_first_page, input run_pages, input last,
                  output ready);
endinterface

`default_nettype wire

/* sv/dpbrt_bitmap_ram.sv */
// dpbrt_bitmap_ram: single write / single read bitmap word store with a
// clearing sweep after reset; no dependencies
`default_nettype none

module dpbrt_bitmap_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned AW    = 10
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  output logic                  busy_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;
  logic [AW-1:0]    clr_addr_q, clr_addr_d;
  logic             clr_busy_q, clr_busy_d;

  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  // sweep has priority, the sequencer holds off until it is over
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_busy_q;

endmodule

`default_nettype wire

/* sv/dpbrt_run_emit.sv */
// dpbrt_run_emit: holds the latest complete run so the last flag can be set,
// and drives the registered run output; depends on dpbrt_pkg, dpbrt_run_if
`default_nettype none

module dpbrt_run_emit (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dpbrt_pkg::emit_req_t req_i,
  output logic                      grant_o,
  dpbrt_run_if.source               run_o
);
  import dpbrt_pkg::*;

  logic   pend_vld_q, pend_vld_d;
  run_t   pend_q, pend_d;
  logic   out_vld_q, out_vld_d;
  run_t   out_q, out_d;
  logic   out_last_q, out_last_d;
  logic   out_free;
  logic   push;

  assign out_free = !out_vld_q || run_o.ready;
  assign grant_o  = !pend_vld_q || out_free;
  // held run moves out when a newer run arrives or the item ends
  assign push     = (req_i.close || req_i.flush) && pend_vld_q && out_free;

  always_comb begin
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    out_last_d = out_last_q;
    if (push) begin
      out_vld_d  = 1'b1;
      out_d      = pend_q;
      out_last_d = req_i.flush;
    end else if (run_o.ready) begin
      out_vld_d  = 1'b0;
    end
    if (req_i.close && grant_o) begin
      pend_vld_d = 1'b1;
      pend_d     = req_i.run;
    end else if (req_i.flush && grant_o) begin
      pend_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign run_o.valid          = out_vld_q;
  assign run_o.run_first_page = out_q.first_page;
  assign run_o.run_pages      = out_q.pages;
  assign run_o.last           = out_last_q;

endmodule

`default_nettype wire

/* sv/demand_page_bitmap_run_tracker.sv */
// demand page bitmap run tracker, top level: one page at a time scan unit
// tracked item: DIV1, DIV2, then RD, LOAD, SCAN, WB per bitmap word, then FLUSH
// free with tracking off: DIS, FLUSH; allocate while off or zero count: IDLE only
// page scan loop takes one bit per cycle unless a run close stalls on the output
// reset (async, active low) clears control and the config register, then a
// clearing sweep zeroes the bitmap before the first request
`default_nettype none

module demand_page_bitmap_run_tracker #(
  parameter int unsigned NUM_PAGES       = 65536,
  parameter int unsigned WORD_BITS       = 64,
  parameter int unsigned MAX_RANGE_PAGES = 128
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cfg_wr_en_i,
  input  wire logic   cfg_wr_data_i,
  dpbrt_req_if.sink   req_i,
  dpbrt_run_if.source run_o
);
  import dpbrt_pkg::*;

  localparam int unsigned NUM_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned BW        = $clog2(WORD_BITS);
  localparam int unsigned CMP_W     = 21;  // wide enough for stores under 2^21 pages
  // page / WORD_BITS by reciprocal: floor reciprocal leaves at most one short
  localparam int unsigned RECIP_SH  = PNUM_W;
  localparam int unsigned RECIP     = (1 << RECIP_SH) / WORD_BITS;
  localparam int unsigned RECIP_W   = $clog2(RECIP + 1);
  localparam int unsigned PROD_W    = PAGE_W + RECIP_W;

  // config register
  logic demand_tracking_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      demand_tracking_q <= 1'b0;
    end else if (cfg_wr_en_i) begin
      demand_tracking_q <= cfg_wr_data_i;
    end
  end

  // sequencer state and scan datapath
  state_e              state_q, state_d;
  logic                func_q, func_d;
  logic [PAGE_W-1:0]   first_q, first_d;
  logic [COUNT_W-1:0]  rem_q, rem_d;      // pages still to scan
  logic [PNUM_W-1:0]   p_q, p_d;          // current page
  logic [PNUM_W-1:0]   q_q, q_d;          // quotient estimate
  logic [PNUM_W-1:0]   wi_q, wi_d;        // current word index
  logic [BW-1:0]       bit_q, bit_d;      // bit of current page in word
  logic [WORD_BITS-1:0] word_q, word_d;
  logic                dirty_q, dirty_d;
  logic                run_act_q, run_act_d;
  logic [PAGE_W-1:0]   run_start_q, run_start_d;
  logic [COUNT_W-1:0]  run_len_q, run_len_d;

  logic                in_fire;
  logic [COUNT_W-1:0]  count_clip;
  logic [PROD_W-1:0]   div_prod;
  logic [PNUM_W-1:0]   q_times_w;
  logic [PNUM_W-1:0]   div_rem;
  logic                page_in_store;
  logic                word_in_store;
  logic                cur_bit;
  logic                last_in_word;
  logic                scan_end;
  logic                need_close;
  logic                stall;

  // bitmap store and run output
  logic                 ram_busy;
  logic                 rd_en;
  logic                 wr_en;
  logic [WORD_BITS-1:0] rd_data;
  emit_req_t            emit_req;
  logic                 emit_grant;

  assign in_fire    = req_i.valid && req_i.ready;
  assign count_clip = (req_i.page_count > COUNT_W'(MAX_RANGE_PAGES))
                      ? COUNT_W'(MAX_RANGE_PAGES) : req_i.page_count;

  // word split of the first page, two registered steps
  assign div_prod  = PROD_W'(first_q) * PROD_W'(RECIP);
  assign q_times_w = PNUM_W'(q_q * WORD_BITS);
  assign div_rem   = {1'b0, first_q} - q_times_w;

  assign page_in_store = CMP_W'(p_q) < CMP_W'(NUM_PAGES);
  assign word_in_store = CMP_W'(wi_q) < CMP_W'(NUM_WORDS);
  // pages past the store always read unmarked
  assign cur_bit       = word_q[bit_q] && page_in_store;
  assign last_in_word  = bit_q == BW'(WORD_BITS - 1);
  assign scan_end      = rem_q == '0;
  // a run ends on an unmarked page of a free, or at the end of the range
  assign need_close    = run_act_q && (scan_end || (func_q && !cur_bit));
  assign stall         = (state_q == ST_SCAN) && need_close && !emit_grant;

  assign req_i.ready = state_q == ST_IDLE;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (!ram_busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire && count_clip != '0) begin
          if (demand_tracking_q) begin
            state_d = ST_DIV1;
          end else if (req_i.func) begin
            state_d = ST_DIS;
          end
        end
      end
      ST_DIV1: state_d = ST_DIV2;
      ST_DIV2: state_d = ST_RD;
      ST_RD:   state_d = ST_LOAD;
      ST_LOAD: state_d = ST_SCAN;
      ST_SCAN: begin
        if (!stall) begin
          if (scan_end) begin
            state_d = ST_WB;
          end else if (last_in_word && rem_q != COUNT_W'(1)) begin
            state_d = ST_WB;
          end
        end
      end
      ST_WB: begin
        state_d = scan_end ? ST_FLUSH : ST_RD;
      end
      ST_DIS: begin
        if (emit_grant) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (emit_grant) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and control outputs
  always_comb begin
    func_d      = func_q;
    first_d     = first_q;
    rem_d       = rem_q;
    p_d         = p_q;
    q_d         = q_q;
    wi_d        = wi_q;
    bit_d       = bit_q;
    word_d      = word_q;
    dirty_d     = dirty_q;
    run_act_d   = run_act_q;
    run_start_d = run_start_q;
    run_len_d   = run_len_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    emit_req            = '0;
    emit_req.run.first_page = run_start_q;
    emit_req.run.pages      = run_len_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          func_d    = req_i.func;
          first_d   = req_i.first_page;
          rem_d     = count_clip;
          p_d       = {1'b0, req_i.first_page};
          run_act_d = 1'b0;
        end
      end
      ST_DIV1: begin
        q_d = PNUM_W'(div_prod >> RECIP_SH);
      end
      ST_DIV2: begin
        // estimate is exact or one short
        if (div_rem >= PNUM_W'(WORD_BITS)) begin
          wi_d  = q_q + 1'b1;
          bit_d = BW'(div_rem - PNUM_W'(WORD_BITS));
        end else begin
          wi_d  = q_q;
          bit_d = BW'(div_rem);
        end
      end
      ST_RD: begin
        rd_en = word_in_store;
      end
      ST_LOAD: begin
        word_d  = word_in_store ? rd_data : '0;
        dirty_d = 1'b0;
      end
      ST_SCAN: begin
        emit_req.close = need_close;
        if (!stall) begin
          if (scan_end) begin
            run_act_d = 1'b0;
          end else begin
            if (!func_q) begin
              if (page_in_store) begin
                word_d[bit_q] = 1'b1;
                dirty_d       = 1'b1;
              end
            end else if (cur_bit) begin
              word_d[bit_q] = 1'b0;
              dirty_d       = 1'b1;
              if (run_act_q) begin
                run_len_d = run_len_q + 1'b1;
              end else begin
                run_start_d = p_q[PAGE_W-1:0];
                run_len_d   = COUNT_W'(1);
                run_act_d   = 1'b1;
              end
            end else begin
              run_act_d = 1'b0;
            end
            p_d   = p_q + 1'b1;
            rem_d = rem_q - 1'b1;
            bit_d = last_in_word ? '0 : bit_q + 1'b1;
          end
        end
      end
      ST_WB: begin
        wr_en = dirty_q && word_in_store;
        if (!scan_end) begin
          wi_d = wi_q + 1'b1;
        end
      end
      ST_DIS: begin
        // tracking off: whole range as a single run
        emit_req.close          = 1'b1;
        emit_req.run.first_page = first_q;
        emit_req.run.pages      = rem_q;
      end
      ST_FLUSH: begin
        emit_req.flush = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      run_act_q <= 1'b0;
      dirty_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      run_act_q <= run_act_d;
      dirty_q   <= dirty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    first_q     <= first_d;
    rem_q       <= rem_d;
    p_q         <= p_d;
    q_q         <= q_d;
    wi_q        <= wi_d;
    bit_q       <= bit_d;
    word_q      <= word_d;
    run_start_q <= run_start_d;
    run_len_q   <= run_len_d;
  end

  dpbrt_bitmap_ram #(
    .DEPTH (NUM_WORDS),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_bitmap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (wi_q[AW-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wi_q[AW-1:0]),
    .wr_data_i (word_q),
    .busy_o    (ram_busy)
  );

  dpbrt_run_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (emit_req),
    .grant_o (emit_grant),
    .run_o   (run_o)
  );

  // no request taken while the bitmap sweep runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_busy |-> !req_i.ready)
    else $error("request accepted during bitmap clear");

  // every released run has at least one page
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_o.valid |-> run_o.run_pages != '0)
    else $error("empty run released");

  // no run left open once the sequencer is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !run_act_q)
    else $error("open run at idle");

  // remaining page count never exceeds the range limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> rem_q <= COUNT_W'(MAX_RANGE_PAGES))
    else $error("scan count beyond range limit");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// testbench for demand_page_bitmap_run_tracker: directed and random range requests
// against a page bitmap predictor, runs checked field by field in order
// depends on dpbrt_pkg, dpbrt_req_if / dpbrt_run_if and the tracker top level
`timescale 1ns / 100ps

module testbench;
  import dpbrt_pkg::*;

  // block configuration, kept equal to the instance below
  localparam int unsigned TRACKED_PAGES = 65536;
  localparam int unsigned WORD_PAGES    = 64;
  localparam int unsigned RANGE_CAP     = 128;

  // request function codes
  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;

  // settle time after the last run, well over the slowest tracked item
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS   = 32;

  // one expected released run
  typedef struct packed {
    run_t run;
    logic last;
  } run_expect_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_wr_en;
  logic cfg_wr_data;

  dpbrt_req_if req_bus ();
  dpbrt_run_if run_bus ();

  demand_page_bitmap_run_tracker #(
    .NUM_PAGES       (TRACKED_PAGES),
    .WORD_BITS       (WORD_PAGES),
    .MAX_RANGE_PAGES (RANGE_CAP)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en),
    .cfg_wr_data_i (cfg_wr_data),
    .req_i         (req_bus),
    .run_o         (run_bus)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state: one commit bit per page and our copy of the tracking register
  bit          committed_map [0:TRACKED_PAGES-1];
  logic        tracking_on;
  run_expect_t run_expect_q [$];

  // idle switches for the two sides, changed per phase
  bit          src_idle;
  bit          sink_idle;

  int unsigned items_sent;
  int unsigned runs_seen;
  int unsigned fault_count;
  int unsigned tracked_phases;
  int unsigned untracked_phases;
  run_expect_t want;

  // pages past the store never read as committed
  function automatic bit page_committed(input int unsigned page);
    return (page < TRACKED_PAGES) ? committed_map[page] : 1'b0;
  endfunction

  // works out the runs released by one accepted transaction and updates the bitmap
  function automatic void predict_range(input logic fn, input logic [PAGE_W-1:0] pg,
                                        input logic [COUNT_W-1:0] cnt);
    int unsigned span;
    int unsigned i;
    int unsigned start;
    bit          have_held;
    run_expect_t held;
    run_expect_t rec;
    span      = (cnt > RANGE_CAP) ? RANGE_CAP : cnt;
    have_held = 1'b0;
    if (span == 0) return;
    if (fn == FN_ALLOC) begin
      if (tracking_on) begin
        for (i = 0; i < span; i++) begin
          if (pg + i < TRACKED_PAGES) committed_map[pg + i] = 1'b1;
        end
      end
      return;
    end
    // tracking off: the whole (cut) range goes back as one run
    if (!tracking_on) begin
      rec.run.first_page = pg;
      rec.run.pages      = span[COUNT_W-1:0];
      rec.last           = 1'b1;
      run_expect_q.push_back(rec);
      return;
    end
    // tracking on: scan low to high, releasing each maximal committed run
    i = 0;
    while (i < span) begin
      if (!page_committed(pg + i)) begin
        i++;
      end else begin
        start = i;
        while (i < span && page_committed(pg + i)) begin
          committed_map[pg + i] = 1'b0;
          i++;
        end
        if (have_held) run_expect_q.push_back(held);
        held.run.first_page = PAGE_W'(pg + start);
        held.run.pages      = COUNT_W'(i - start);
        held.last           = 1'b0;
        have_held           = 1'b1;
      end
    end
    // the final run of the free carries the last flag
    if (have_held) begin
      held.last = 1'b1;
      run_expect_q.push_back(held);
    end
  endfunction

  // sends one range request; valid stays up so back-to-back transactions need no gap
  task automatic send_range(input logic fn, input logic [PAGE_W-1:0] pg,
                            input logic [COUNT_W-1:0] cnt);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid      <= 1'b1;
    req_bus.func       <= fn;
    req_bus.first_page <= pg;
    req_bus.page_count <= cnt;
    do @(posedge clk_i); while (!(req_bus.valid && req_bus.ready));
    predict_range(fn, pg, cnt);
    items_sent++;
  endtask

  // drop valid, wait out every expected run, then let any allocate still in flight finish
  task automatic drain_block();
    req_bus.valid <= 1'b0;
    while (run_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write, only ever issued with the block idle
  task automatic set_tracking(input logic enable);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= enable;
    @(posedge clk_i);
    tracking_on = enable;
    cfg_wr_en <= 1'b0;
    if (enable) tracked_phases++;
    else untracked_phases++;
  endtask

  // tracking off after reset: whole ranges come back, allocates do nothing
  task automatic test_untracked_free();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    send_range(FN_FREE, 16'd0, 8'd1);
    send_range(FN_FREE, 16'd0, 8'd0);          // empty range, no run
    send_range(FN_FREE, 16'd4096, 8'd128);
    send_range(FN_FREE, 16'd1000, 8'd255);     // oversized, cut to the cap
    send_range(FN_FREE, 16'hFFFF, 8'd128);     // runs past the store, still one run
    send_range(FN_ALLOC, 16'd300, 8'd8);       // ignored while untracked
    send_range(FN_ALLOC, 16'hFFFF, 8'd255);
    send_range(FN_FREE, 16'd300, 8'd8);
    drain_block();
  endtask

  // tracking on: marked runs, gaps, word boundaries and the top of the store
  task automatic test_tracked_runs();
    set_tracking(1'b1);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    send_range(FN_FREE, 16'd300, 8'd8);        // allocated while untracked, nothing marked
    send_range(FN_ALLOC, 16'd0, 8'd128);
    send_range(FN_FREE, 16'd0, 8'd255);        // one full-cap run
    send_range(FN_ALLOC, 16'd65530, 8'd20);    // only six pages fit in the store
    send_range(FN_FREE, 16'd65520, 8'd40);
    send_range(FN_ALLOC, 16'd100, 8'd0);
    send_range(FN_FREE, 16'd100, 8'd5);        // nothing marked, no run
    send_range(FN_ALLOC, 16'd200, 8'd3);
    send_range(FN_ALLOC, 16'd210, 8'd1);
    send_range(FN_ALLOC, 16'd250, 8'd10);
    send_range(FN_FREE, 16'd190, 8'd128);      // three runs, last on the third
    send_range(FN_FREE, 16'd190, 8'd128);      // already cleared
    send_range(FN_ALLOC, 16'd60, 8'd10);       // straddles a bitmap word
    send_range(FN_FREE, 16'd64, 8'd2);
    send_range(FN_FREE, 16'd50, 8'd30);
    drain_block();
  endtask

  // every other page marked, so one free releases the most runs it can
  task automatic test_scattered_pages();
    logic [PAGE_W-1:0] base;
    int unsigned       j;
    base      = PAGE_W'(40000 + $urandom_range(0, 20000));
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    for (j = 0; j < 64; j++) send_range(FN_ALLOC, PAGE_W'(base + 2 * j), 8'd1);
    send_range(FN_FREE, base, 8'd128);
    drain_block();
  endtask

  // random traffic clustered in small windows so allocates and frees overlap
  task automatic test_random_traffic();
    int unsigned       phase;
    int unsigned       n;
    int unsigned       pick;
    logic [PAGE_W-1:0] base;
    logic              fn;
    logic [PAGE_W-1:0] pg;
    logic [COUNT_W-1:0] cnt;
    base = 16'd0;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_tracking(phase % 3 != 1);
      src_idle  = (phase != 2);
      sink_idle = (phase != 3);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // fresh window now and then: bottom, top of the store or anywhere
        if (n % 8 == 0) begin
          pick = $urandom_range(0, 3);
          if (pick == 0) base = 16'd0;
          else if (pick == 1) base = 16'hFF00;
          else base = PAGE_W'($urandom_range(0, 65535));
        end
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          // noise: any fields at all, zero and oversized counts too
          fn  = 1'($urandom_range(0, 1));
          pg  = PAGE_W'($urandom_range(0, 65535));
          cnt = COUNT_W'($urandom_range(0, 255));
        end else if (pick < 55) begin
          fn  = FN_ALLOC;
          pg  = PAGE_W'(base + $urandom_range(0, 255));
          cnt = COUNT_W'($urandom_range(1, 24));
        end else begin
          fn  = FN_FREE;
          pg  = PAGE_W'(base + $urandom_range(0, 200));
          cnt = COUNT_W'(($urandom_range(0, 7) == 0) ? $urandom_range(129, 255)
                                                     : $urandom_range(1, 128));
        end
        send_range(fn, pg, cnt);
      end
      drain_block();
    end
  endtask

  // run side: random stall before each transaction, none in some phases
  initial begin : run_sink
    int unsigned gap;
    run_bus.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      gap = sink_idle ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        run_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      run_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(run_bus.valid && run_bus.ready));
    end
  end

  // compare each released run with the oldest expectation
  always @(posedge clk_i) begin
    if (run_bus.valid && run_bus.ready) begin
      runs_seen++;
      if (run_expect_q.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected run: page %0d pages %0d last %0b",
                   run_bus.run_first_page, run_bus.run_pages, run_bus.last);
      end else begin
        want = run_expect_q.pop_front();
        if (want.run.first_page !== run_bus.run_first_page ||
            want.run.pages !== run_bus.run_pages || want.last !== run_bus.last) begin
          fault_count++;
          if (fault_count <= 10)
            $display("run mismatch: expected page %0d pages %0d last %0b, got %0d %0d %0b",
                     want.run.first_page, want.run.pages, want.last,
                     run_bus.run_first_page, run_bus.run_pages, run_bus.last);
        end
      end
    end
  end

  // main sequence
  initial begin
    rst_ni             <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= 1'b0;
    req_bus.valid      <= 1'b0;
    req_bus.func       <= FN_ALLOC;
    req_bus.first_page <= '0;
    req_bus.page_count <= '0;
    tracking_on      = 1'b0;
    src_idle         = 1'b0;
    sink_idle        = 1'b0;
    items_sent       = 0;
    runs_seen        = 0;
    fault_count      = 0;
    tracked_phases   = 0;
    untracked_phases = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the clearing sweep holds off the first transaction through ready
    @(posedge clk_i);

    test_untracked_free();
    test_tracked_runs();
    test_scattered_pages();
    test_random_traffic();
    set_tracking(1'b0);

    $display("covered %0d range requests and %0d released runs", items_sent, runs_seen);
    $display("tracking written on %0d times and off %0d times, with and without idling",
             tracked_phases, untracked_phases);
    if (fault_count == 0 && run_expect_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #4000000;
    $display("testbench: errors");
    $finish;
  end

endmodule

/* files.f */
sv/dpbrt_pkg.sv
sv/dpbrt_if.sv
sv/dpbrt_bitmap_ram.sv
sv/dpbrt_run_emit.sv
sv/demand_page_bitmap_run_tracker.sv
tb/testbench.sv
